[rtl/core/flc_pkg.sv]
// Shared types, codes and widths for the flow counter table.
`default_nettype none

package flc_pkg;

    localparam int ACTION_W  = 3;
    localparam int INDEX_W   = 10;
    localparam int VALUE_W   = 64;
    localparam int TOTAL_W   = 11;
    localparam int STATUS_W  = 2;
    localparam int CFG_W     = 11;
    // Wide enough for any table depth in the supported range and for the limit register.
    localparam int LIMIT_W   = 17;

    localparam int TABLE_DEPTH_DEFAULT = 1024;
    localparam logic [CFG_W-1:0] CFG_LIMIT_RESET = 11'd1024;

    localparam logic [ACTION_W-1:0] ACT_INCREMENT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ALLOCATE  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR     = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ      = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_EXIST = 2'd2;

    // One table entry as stored in the counter memory.
    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
    } t_entry;

    // Outcome of one item: the write-back to the table and the result beat.
    typedef struct packed {
        logic                wr_en;
        t_entry              wr_entry;
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  value;
        logic [TOTAL_W-1:0]  total;
    } t_upd;

endpackage

`default_nettype wire

[rtl/core/flow_counter_table_core.sv]
// Top level of the flow counter table: table memory, pipeline and result register.
`default_nettype none

// The flow counter table keeps one 64-bit counter and one valid mark per index,
// plus a running count of valid entries. An input beat (action, counter index)
// enters on the i_in_valid / o_in_ready handshake; every input beat produces
// exactly one result beat (status, value, active count) on o_out_valid /
// i_out_ready, in order.
//
// The counter limit register is written through i_cfg_wr_en / i_cfg_wr_data.
// Write it only while no beats are in flight.
//
// The edge that accepts a beat reads the table memory into the pipeline stage;
// when that stage advances, the updated entry is written back and the result
// register is loaded. Throughput is one beat per cycle unless the receiver stalls.
// The entry just written is forwarded to the following beat for back-to-back hits.
//
// After reset the block sweeps the table memory once, one entry per cycle, to
// clear every valid mark, and o_in_ready stays low during the pass. When the
// receiver stalls, the result register holds its beat; one more beat can sit in
// the pipeline stage behind it, and only then does o_in_ready drop.
module flow_counter_table_core
    import flc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Input channel
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [ACTION_W-1:0] i_action,
    input  wire logic [INDEX_W-1:0]  i_counter_index,
    // Result channel
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic      [STATUS_W-1:0] o_status,
    output logic      [VALUE_W-1:0]  o_value,
    output logic      [TOTAL_W-1:0]  o_active_count,
    // Configuration
    input  wire logic                i_cfg_wr_en,
    input  wire logic [CFG_W-1:0]    i_cfg_wr_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);
    localparam logic [LIMIT_W-1:0] DEPTH_LIMIT = LIMIT_W'(TABLE_DEPTH);

    // Configuration and effective limit.
    logic [CFG_W-1:0]   r_limit;
    logic [LIMIT_W-1:0] eff_limit;

    // Clearing pass.
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    // Pipeline stage behind the memory read.
    logic                r_s1_valid;
    logic [ACTION_W-1:0] r_s1_action;
    logic [INDEX_W-1:0]  r_s1_index;
    logic [AW-1:0]       r_s1_addr;

    // Last entry written by an item, forwarded over the memory's read latency.
    logic          r_fwd_valid;
    logic [AW-1:0] r_fwd_addr;
    t_entry        r_fwd_entry;

    logic [TOTAL_W-1:0] r_total;

    // Result register.
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [VALUE_W-1:0]  r_out_value;
    logic [TOTAL_W-1:0]  r_out_total;

    logic               in_accept;
    logic               s1_advance;
    logic [LIMIT_W-1:0] index_wide;
    logic [AW-1:0]      rd_addr;
    t_entry             ram_rd_entry;
    t_entry             cur_entry;
    t_upd               upd;
    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    t_entry             ram_wr_entry;
    logic               item_write;

    logic n_s1_valid;
    logic n_out_valid;

    assign eff_limit  = (LIMIT_W'(r_limit) < DEPTH_LIMIT) ? LIMIT_W'(r_limit) : DEPTH_LIMIT;
    assign s1_advance = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_clearing && (!r_s1_valid || s1_advance);
    assign in_accept  = i_in_valid && o_in_ready;

    // Indices beyond the table are rejected later, so the truncation is harmless.
    assign index_wide = LIMIT_W'(i_counter_index);
    assign rd_addr    = index_wide[AW-1:0];

    assign cur_entry  = (r_fwd_valid && r_fwd_addr == r_s1_addr) ? r_fwd_entry : ram_rd_entry;
    assign item_write = s1_advance && upd.wr_en;

    // The clearing pass owns the write port until it finishes.
    always_comb begin
        if (r_clearing) begin
            ram_wr_en    = 1'b1;
            ram_wr_addr  = r_clr_addr;
            ram_wr_entry = '0;
        end else begin
            ram_wr_en    = item_write;
            ram_wr_addr  = r_s1_addr;
            ram_wr_entry = upd.wr_entry;
        end
    end

    flc_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_entry),
        .i_rd_en   (in_accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_rd_entry)
    );

    flc_update u_update (
        .i_entry  (cur_entry),
        .i_action (r_s1_action),
        .i_index  (r_s1_index),
        .i_limit  (eff_limit),
        .i_total  (r_total),
        .o_upd    (upd)
    );

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_advance) begin
            n_s1_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (s1_advance) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= CFG_LIMIT_RESET;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_total     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    r_clearing <= 1'b0;
                end
            end
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            if (r_clearing) begin
                r_fwd_valid <= 1'b0;
            end else if (item_write) begin
                r_fwd_valid <= 1'b1;
            end
            if (s1_advance) begin
                r_total <= upd.total;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_action <= i_action;
            r_s1_index  <= i_counter_index;
            r_s1_addr   <= rd_addr;
        end
        if (item_write) begin
            r_fwd_addr  <= r_s1_addr;
            r_fwd_entry <= upd.wr_entry;
        end
        if (s1_advance) begin
            r_out_status <= upd.status;
            r_out_value  <= upd.value;
            r_out_total  <= upd.total;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_value        = r_out_value;
    assign o_active_count = r_out_total;

    // No beat is in flight while the table is being cleared.
    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> (!r_s1_valid && !r_out_valid))
        else $error("beat in flight during clearing pass");

    // The active count moves only when an item completes.
    a_total_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_advance |=> $stable(r_total))
        else $error("active count changed without an item");

    // One item changes the active count by at most one.
    a_total_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_advance |=> (r_total == $past(r_total)
                        || r_total == TOTAL_W'($past(r_total) + TOTAL_W'(1))
                        || r_total == TOTAL_W'($past(r_total) - TOTAL_W'(1))))
        else $error("active count stepped by more than one");

    // Only successful actions write the table.
    a_write_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        item_write |-> (upd.status == ST_OK && !r_clearing))
        else $error("table written by a failed action");

endmodule

`default_nettype wire

[rtl/core/flc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module flc_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/flc_update.sv]
// Per-item decision logic: status, new entry contents and new active count.
`default_nettype none

module flc_update
    import flc_pkg::*;
(
    input  wire t_entry              i_entry,
    input  wire logic [ACTION_W-1:0] i_action,
    input  wire logic [INDEX_W-1:0]  i_index,
    input  wire logic [LIMIT_W-1:0]  i_limit,
    input  wire logic [TOTAL_W-1:0]  i_total,
    output t_upd                     o_upd
);

    logic [VALUE_W-1:0] base_value;
    logic               out_of_range;

    // An entry that is not valid counts from zero once it gets allocated.
    assign base_value   = i_entry.valid ? i_entry.value : '0;
    assign out_of_range = (LIMIT_W'(i_index) >= i_limit);

    always_comb begin
        o_upd          = '0;
        o_upd.status   = ST_OK;
        o_upd.total    = i_total;
        if (i_action > ACT_READ) begin
            // Unknown actions leave everything alone.
        end else if (i_index == '0) begin
            if (i_action == ACT_READ) begin
                o_upd.status = ST_BAD_INDEX;
            end
        end else if (out_of_range) begin
            o_upd.status = ST_BAD_INDEX;
        end else if (i_action == ACT_INCREMENT || i_action == ACT_ALLOCATE) begin
            o_upd.wr_en          = 1'b1;
            o_upd.wr_entry.valid = 1'b1;
            o_upd.wr_entry.value = (i_action == ACT_INCREMENT) ?
                                   base_value + VALUE_W'(1) : base_value;
            o_upd.value          = o_upd.wr_entry.value;
            if (!i_entry.valid) begin
                o_upd.total = i_total + TOTAL_W'(1);
            end
        end else if (!i_entry.valid) begin
            o_upd.status = ST_NOT_EXIST;
        end else begin
            case (i_action)
                ACT_DELETE: begin
                    o_upd.wr_en = 1'b1;
                    o_upd.total = i_total - TOTAL_W'(1);
                end
                ACT_CLEAR: begin
                    o_upd.wr_en          = 1'b1;
                    o_upd.wr_entry.valid = 1'b1;
                end
                default: begin
                    o_upd.value = i_entry.value;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
